// File: design/itf_pkg.sv
// Shared types and constants for the integer text formatter.
package itf_pkg;

  typedef enum logic [1:0] {
    RADIX_DEC,
    RADIX_BIN,
    RADIX_OCT,
    RADIX_HEX
  } radix_e;

  // Control from the sequencer to the digit unit.
  typedef struct packed {
    logic   load;
    logic   shift;
    radix_e radix;
  } dig_ctrl_t;

  // Status from the digit unit to the sequencer.
  typedef struct packed {
    logic       done;
    logic [6:0] ndig;
    logic [3:0] digit;
  } dig_stat_t;

  localparam int unsigned DigBits = 80;
  localparam logic [7:0] AsciiZero = 8'h30;

  localparam logic [2:0] REG_NUM_FORMAT   = 3'd0;
  localparam logic [2:0] REG_GROUP_SIZE   = 3'd1;
  localparam logic [2:0] REG_SEPARATORS   = 3'd2;
  localparam logic [2:0] REG_DECIMALS     = 3'd3;
  localparam logic [2:0] REG_SIGN_STYLE   = 3'd4;
  localparam logic [2:0] REG_PAD_CHAR     = 3'd5;
  localparam logic [2:0] REG_FIELD_WIDTH  = 3'd6;
  localparam logic [2:0] REG_LAYOUT_FLAGS = 3'd7;

endpackage

// File: design/itf_digits.sv
// Digit unit: bit-serial binary to BCD conversion, digit normalization and digit shift-out.
module itf_digits import itf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  dig_ctrl_t   ctrl_i,
  input  logic [63:0] mag_i,
  output dig_stat_t   stat_o
);

  typedef enum logic [1:0] {
    D_IDLE,
    D_CONV,
    D_NORM,
    D_READY
  } dstate_e;

  dstate_e              state_q, state_d;
  radix_e               radix_q, radix_d;
  logic [DigBits-1:0]   dr_q, dr_d;
  logic [63:0]          mag_q, mag_d;
  logic [6:0]           cnt_q, cnt_d;
  logic [6:0]           slots_q, slots_d;
  logic [3:0]           top;
  logic [DigBits-1:0]   dr_shifted;
  logic [DigBits-1:0]   adj;

  always_comb begin
    unique case (radix_q)
      RADIX_BIN: begin
        top        = {3'b000, dr_q[DigBits-1]};
        dr_shifted = dr_q << 1;
      end
      RADIX_OCT: begin
        top        = {1'b0, dr_q[DigBits-1 -: 3]};
        dr_shifted = dr_q << 3;
      end
      default: begin
        top        = dr_q[DigBits-1 -: 4];
        dr_shifted = dr_q << 4;
      end
    endcase
  end

  // Double-dabble correction: every BCD digit of five or more gets three added.
  always_comb begin
    for (int i = 0; i < DigBits / 4; i++) begin
      adj[4*i +: 4] = (dr_q[4*i +: 4] >= 4'd5) ? dr_q[4*i +: 4] + 4'd3 : dr_q[4*i +: 4];
    end
  end

  always_comb begin
    state_d = state_q;
    radix_d = radix_q;
    dr_d    = dr_q;
    mag_d   = mag_q;
    cnt_d   = cnt_q;
    slots_d = slots_q;
    if (ctrl_i.load) begin
      radix_d = ctrl_i.radix;
      unique case (ctrl_i.radix)
        RADIX_BIN: begin
          dr_d    = {mag_i, 16'h0000};
          slots_d = 7'd64;
          state_d = D_NORM;
        end
        RADIX_OCT: begin
          dr_d    = {2'b00, mag_i, 14'h0000};
          slots_d = 7'd22;
          state_d = D_NORM;
        end
        RADIX_HEX: begin
          dr_d    = {mag_i, 16'h0000};
          slots_d = 7'd16;
          state_d = D_NORM;
        end
        default: begin
          dr_d    = '0;
          mag_d   = mag_i;
          cnt_d   = 7'd64;
          state_d = D_CONV;
        end
      endcase
    end else begin
      unique case (state_q)
        D_CONV: begin
          dr_d  = {adj[DigBits-2:0], mag_q[63]};
          mag_d = mag_q << 1;
          cnt_d = cnt_q - 7'd1;
          if (cnt_q == 7'd1) begin
            slots_d = 7'd20;
            state_d = D_NORM;
          end
        end
        D_NORM: begin
          // Strip leading zero digits, but always keep at least one digit.
          if (top == 4'd0 && slots_q > 7'd1) begin
            dr_d    = dr_shifted;
            slots_d = slots_q - 7'd1;
          end else begin
            state_d = D_READY;
          end
        end
        D_READY: begin
          if (ctrl_i.shift) begin
            dr_d = dr_shifted;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      radix_q <= RADIX_DEC;
    end else begin
      state_q <= state_d;
      radix_q <= radix_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dr_q    <= dr_d;
    mag_q   <= mag_d;
    cnt_q   <= cnt_d;
    slots_q <= slots_d;
  end

  assign stat_o.done  = (state_q == D_READY);
  assign stat_o.ndig  = slots_q;
  assign stat_o.digit = top;

endmodule

// File: design/integer_text_formatter_unit.sv
// Top level: formats one signed 64-bit integer as ASCII text in packed words.
// Sequence: bit-serial conversion in decimal mode, stripping of leading zero digits, group
// counting over the digits (skipped when grouping is off), a layout step, then emission of
// the characters (separators included) through nine text segments.
// Throughput: one value at a time; start is taken again once busy falls after the last word.
// Reset: async, active low, control and config registers only; the receiver cannot stall.
module integer_text_formatter_unit import itf_pkg::*; #(
  parameter int unsigned CHARS_PER_RESULT = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] value_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  output logic        out_valid_o,
  output logic [63:0] chars_o,
  output logic [3:0]  char_count_o,
  output logic        last_word_o,
  output logic        overflow_error_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIGITS,
    ST_GROUP,
    ST_LEN,
    ST_EMIT
  } state_e;

  typedef enum logic [3:0] {
    SEG_PAD1,
    SEG_FRONT,
    SEG_PAD2,
    SEG_PRE,
    SEG_DIG,
    SEG_SUF,
    SEG_PAD3,
    SEG_BACK,
    SEG_PAD4
  } seg_e;

  localparam logic [3:0] WordLast = 4'(CHARS_PER_RESULT - 1);

  // Configuration registers.
  logic [3:0]  fmt_q, fmt_d;
  logic [3:0]  grp_q, grp_d;
  logic [15:0] sep_q, sep_d;
  logic [6:0]  dec_q, dec_d;
  logic [2:0]  style_q, style_d;
  logic [7:0]  padc_q, padc_d;
  logic [7:0]  fw_q, fw_d;
  logic [1:0]  flags_q, flags_d;

  state_e      state_q, state_d;
  seg_e        seg_q, seg_d, seg_nx;
  logic        neg_q, neg_d;
  logic        zero_q, zero_d;
  logic [6:0]  j_q, j_d;
  logic [3:0]  m_q, m_d;
  logic [6:0]  sepn_q, sepn_d;
  logic [7:0]  rem_q, rem_d;
  logic [7:0]  cnt_q, cnt_d;
  logic        sep_pend_q, sep_pend_d;
  logic [63:0] wbuf_q, wbuf_d;
  logic [3:0]  wcnt_q, wcnt_d;

  logic        valid_q, valid_d;
  logic [63:0] chars_q, chars_d;
  logic [3:0]  count_q, count_d;
  logic        last_q, last_d;
  logic        err_q, err_d;

  dig_ctrl_t   dctrl;
  dig_stat_t   dstat;
  logic [63:0] mag;

  // Layout, from registers the user must keep stable while an item is in work (not enforced).
  logic        is_dec, right, fixed, sign_first, lower;
  logic [1:0]  pre_len;
  logic [7:0]  suf_len;
  logic [7:0]  fch, bch;
  logic        flen, blen;
  logic [8:0]  total;
  logic [7:0]  pad;
  logic        ovf;
  logic [7:0]  pad1, pad2, pad3, pad4, nx_len;
  logic [7:0]  ch, digch;
  logic        emit;
  logic [63:0] wb;
  radix_e      radix;

  itf_digits u_digits (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (dctrl),
    .mag_i  (mag),
    .stat_o (dstat)
  );

  always_comb begin
    unique case (fmt_q) inside
      4'd1, 4'd2:               radix = RADIX_BIN;
      4'd3, 4'd4:               radix = RADIX_OCT;
      [4'd5:4'd8]:              radix = RADIX_HEX;
      default:                  radix = RADIX_DEC;
    endcase
  end

  assign is_dec = (fmt_q == 4'd0) || (fmt_q > 4'd8);
  assign lower  = (fmt_q == 4'd5) || (fmt_q == 4'd7);
  assign right  = flags_q[0];
  assign fixed  = flags_q[1];
  assign sign_first = !((style_q == 3'd6) || (style_q == 3'd7) || (padc_q == AsciiZero) ||
                        (fixed && ((style_q == 3'd4) || (style_q == 3'd5))));

  always_comb begin
    if (zero_q) begin
      pre_len = 2'd0;
      suf_len = 8'd0;
    end else begin
      pre_len = (fmt_q == 4'd3) ? 2'd1 :
                ((fmt_q == 4'd7) || (fmt_q == 4'd8)) ? 2'd2 : 2'd0;
      suf_len = ((fmt_q == 4'd0) && (dec_q != 7'd0)) ? {1'b0, dec_q} + 8'd1 :
                (fmt_q == 4'd2) ? 8'd1 : 8'd0;
    end
  end

  // Sign characters in front of and behind the number.
  always_comb begin
    flen = 1'b0;
    blen = 1'b0;
    fch  = 8'h2D;
    bch  = 8'h2D;
    if (neg_q) begin
      unique case (style_q)
        3'd0, 3'd1: flen = 1'b1;
        3'd2, 3'd3: blen = 1'b1;
        3'd6, 3'd7: begin
          flen = right;
          blen = !right;
        end
        default: begin
          flen = 1'b1;
          blen = 1'b1;
          fch  = 8'h28;
          bch  = 8'h29;
        end
      endcase
    end else begin
      fch = 8'h2B;
      bch = 8'h2B;
      unique case (style_q)
        3'd1: flen = 1'b1;
        3'd3: blen = 1'b1;
        3'd7: begin
          flen = right;
          blen = !right;
        end
        3'd5: begin
          flen = 1'b1;
          blen = 1'b1;
          fch  = padc_q;
          bch  = padc_q;
        end
        default: begin
        end
      endcase
    end
  end

  assign total = 9'(pre_len) + 9'(dstat.ndig) + 9'(sepn_q) + 9'(suf_len) +
                 9'(flen) + 9'(blen);
  assign pad   = ({1'b0, fw_q} > total) ? 8'({1'b0, fw_q} - total) : 8'd0;
  assign ovf   = fixed && (fw_q != 8'd0) && (total > {1'b0, fw_q});
  assign pad1  = (sign_first && right) ? pad : 8'd0;
  assign pad2  = (!sign_first && right) ? pad : 8'd0;
  assign pad3  = (!sign_first && !right) ? pad : 8'd0;
  assign pad4  = (sign_first && !right) ? pad : 8'd0;

  always_comb begin
    if (dstat.digit < 4'd10) begin
      digch = AsciiZero + {4'd0, dstat.digit};
    end else begin
      digch = {4'd0, dstat.digit} - 8'd10 + (lower ? 8'h61 : 8'h41);
    end
  end

  always_comb begin
    unique case (seg_q)
      SEG_PAD1:  seg_nx = SEG_FRONT;
      SEG_FRONT: seg_nx = SEG_PAD2;
      SEG_PAD2:  seg_nx = SEG_PRE;
      SEG_PRE:   seg_nx = SEG_DIG;
      SEG_DIG:   seg_nx = SEG_SUF;
      SEG_SUF:   seg_nx = SEG_PAD3;
      SEG_PAD3:  seg_nx = SEG_BACK;
      SEG_BACK:  seg_nx = SEG_PAD4;
      default:   seg_nx = SEG_PAD4;
    endcase
    unique case (seg_nx)
      SEG_FRONT: nx_len = 8'(flen);
      SEG_PAD2:  nx_len = pad2;
      SEG_PRE:   nx_len = 8'(pre_len);
      SEG_DIG:   nx_len = 8'(dstat.ndig);
      SEG_SUF:   nx_len = suf_len;
      SEG_PAD3:  nx_len = pad3;
      SEG_BACK:  nx_len = 8'(blen);
      SEG_PAD4:  nx_len = pad4;
      default:   nx_len = pad1;
    endcase
  end

  always_comb begin
    fmt_d      = fmt_q;
    grp_d      = grp_q;
    sep_d      = sep_q;
    dec_d      = dec_q;
    style_d    = style_q;
    padc_d     = padc_q;
    fw_d       = fw_q;
    flags_d    = flags_q;
    state_d    = state_q;
    seg_d      = seg_q;
    neg_d      = neg_q;
    zero_d     = zero_q;
    j_d        = j_q;
    m_d        = m_q;
    sepn_d     = sepn_q;
    rem_d      = rem_q;
    cnt_d      = cnt_q;
    sep_pend_d = sep_pend_q;
    wbuf_d     = wbuf_q;
    wcnt_d     = wcnt_q;
    valid_d    = 1'b0;
    chars_d    = chars_q;
    count_d    = count_q;
    last_d     = last_q;
    err_d      = err_q;
    dctrl.load  = 1'b0;
    dctrl.shift = 1'b0;
    dctrl.radix = radix;
    mag   = value_i[63] ? (~value_i + 64'd1) : value_i;
    emit  = 1'b0;
    ch    = padc_q;
    wb    = wbuf_q;

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_NUM_FORMAT:   fmt_d   = cfg_data_i[3:0];
        REG_GROUP_SIZE:   grp_d   = cfg_data_i[3:0];
        REG_SEPARATORS:   sep_d   = cfg_data_i;
        REG_DECIMALS:     dec_d   = cfg_data_i[6:0];
        REG_SIGN_STYLE:   style_d = cfg_data_i[2:0];
        REG_PAD_CHAR:     padc_d  = cfg_data_i[7:0];
        REG_FIELD_WIDTH:  fw_d    = cfg_data_i[7:0];
        REG_LAYOUT_FLAGS: flags_d = cfg_data_i[1:0];
        default: begin
        end
      endcase
    end

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          neg_d      = value_i[63];
          zero_d     = (value_i == 64'd0);
          dctrl.load = 1'b1;
          state_d    = ST_DIGITS;
        end
      end
      ST_DIGITS: begin
        if (dstat.done) begin
          j_d     = 7'd1;
          m_d     = 4'd0;
          sepn_d  = 7'd0;
          state_d = ST_GROUP;
        end
      end
      ST_GROUP: begin
        // Walk the digits from the least significant end; m ends at (digits-1) mod group.
        if ((grp_q == 4'd0) || (j_q >= dstat.ndig)) begin
          state_d = ST_LEN;
        end else begin
          if (m_q + 4'd1 == grp_q) begin
            sepn_d = sepn_q + 7'd1;
            m_d    = 4'd0;
          end else begin
            m_d = m_q + 4'd1;
          end
          j_d = j_q + 7'd1;
        end
      end
      ST_LEN: begin
        if (ovf) begin
          valid_d = 1'b1;
          chars_d = 64'd0;
          count_d = 4'd0;
          last_d  = 1'b1;
          err_d   = 1'b1;
          state_d = ST_IDLE;
        end else begin
          seg_d      = SEG_PAD1;
          cnt_d      = pad1;
          rem_d      = 8'(total + 9'(pad));
          sep_pend_d = 1'b0;
          wbuf_d     = 64'd0;
          wcnt_d     = 4'd0;
          state_d    = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (cnt_q == 8'd0 && !sep_pend_q) begin
          if (seg_q == SEG_PAD4) begin
            state_d = ST_IDLE;
          end else begin
            seg_d = seg_nx;
            cnt_d = nx_len;
          end
        end else begin
          emit  = 1'b1;
          cnt_d = cnt_q - 8'd1;
          unique case (seg_q)
            SEG_FRONT: ch = fch;
            SEG_BACK:  ch = bch;
            SEG_PRE:   ch = (cnt_q == 8'(pre_len)) ? AsciiZero : 8'h78;
            SEG_SUF: begin
              if (!is_dec) begin
                ch = 8'h62;
              end else if (cnt_q == suf_len) begin
                ch = sep_q[15:8];
              end else begin
                ch = AsciiZero;
              end
            end
            SEG_DIG: begin
              if (sep_pend_q) begin
                ch         = sep_q[7:0];
                sep_pend_d = 1'b0;
                cnt_d      = cnt_q;
              end else begin
                ch          = digch;
                dctrl.shift = 1'b1;
                // A separator follows every digit with a nonzero multiple of the group after it.
                if (cnt_q > 8'd1 && grp_q != 4'd0) begin
                  if (m_q == 4'd0) begin
                    sep_pend_d = 1'b1;
                    m_d        = grp_q - 4'd1;
                  end else begin
                    m_d = m_q - 4'd1;
                  end
                end
              end
            end
            default: ch = padc_q;
          endcase
        end
      end
      default: begin
      end
    endcase

    if (emit) begin
      wb[8*wcnt_q[2:0] +: 8] = ch;
      rem_d = rem_q - 8'd1;
      if (wcnt_q == WordLast || rem_q == 8'd1) begin
        valid_d = 1'b1;
        chars_d = wb;
        count_d = wcnt_q + 4'd1;
        last_d  = (rem_q == 8'd1);
        err_d   = 1'b0;
        wbuf_d  = 64'd0;
        wcnt_d  = 4'd0;
      end else begin
        wbuf_d = wb;
        wcnt_d = wcnt_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q      <= 4'd0;
      grp_q      <= 4'd0;
      sep_q      <= 16'h2E2C;
      dec_q      <= 7'd0;
      style_q    <= 3'd0;
      padc_q     <= 8'h20;
      fw_q       <= 8'd0;
      flags_q    <= 2'd0;
      state_q    <= ST_IDLE;
      seg_q      <= SEG_PAD1;
      sep_pend_q <= 1'b0;
      valid_q    <= 1'b0;
    end else begin
      fmt_q      <= fmt_d;
      grp_q      <= grp_d;
      sep_q      <= sep_d;
      dec_q      <= dec_d;
      style_q    <= style_d;
      padc_q     <= padc_d;
      fw_q       <= fw_d;
      flags_q    <= flags_d;
      state_q    <= state_d;
      seg_q      <= seg_d;
      sep_pend_q <= sep_pend_d;
      valid_q    <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q   <= neg_d;
    zero_q  <= zero_d;
    j_q     <= j_d;
    m_q     <= m_d;
    sepn_q  <= sepn_d;
    rem_q   <= rem_d;
    cnt_q   <= cnt_d;
    wbuf_q  <= wbuf_d;
    wcnt_q  <= wcnt_d;
    chars_q <= chars_d;
    count_q <= count_d;
    last_q  <= last_d;
    err_q   <= err_d;
  end

  assign busy             = (state_q != ST_IDLE);
  assign out_valid_o      = valid_q;
  assign chars_o          = chars_q;
  assign char_count_o     = count_q;
  assign last_word_o      = last_q;
  assign overflow_error_o = err_q;

`ifndef ASSERT_OFF
  a_ovf_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && overflow_error_o |-> char_count_o == 4'd0 && last_word_o)
    else $error("overflow result carries characters");
  a_mid_word_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_word_o |-> busy)
    else $error("text stopped before its last word");
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted value did not raise busy");
  a_word_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !overflow_error_o |->
      char_count_o != 4'd0 && char_count_o <= 4'(CHARS_PER_RESULT))
    else $error("word character count out of range");
`endif

endmodule
